>>> src/crt_pkg.sv
// Shared types and constants of the component registration table.
// Depends on nothing; imported by component_registration_table.
package crt_pkg;

    // Operation codes carried in the op field of an input beat.
    localparam logic [2:0] OP_FIND_KEY    = 3'd0;
    localparam logic [2:0] OP_FIND_HANDLE = 3'd1;
    localparam logic [2:0] OP_ADD_KEY     = 3'd2;
    localparam logic [2:0] OP_ADD_HANDLE  = 3'd3;
    localparam logic [2:0] OP_READ_INDEX  = 3'd4;
    localparam logic [2:0] OP_COUNT       = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_MISS    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Configuration register index, taken from paddr[2].
    localparam logic REG_HOST_ADDRESS = 1'b0;
    localparam logic REG_FIRST_PORT   = 1'b1;

    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 120;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  component;
        logic [7:0]  inst;
        logic [7:0]  node;
        logic [7:0]  subsystem;
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] index;
        t_entry     entry;
    } t_result;

endpackage

>>> src/crt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used as the table storage of component_registration_table.
module crt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/component_registration_table.sv
// Top level of the component registration table: APB register port, stream
// ports, search sequencer and output register. Depends on crt_pkg and crt_ram.
//
// Find and add scan the used entries from index 0, one compare per cycle over
// the table RAM's single read port; read index does one RAM read, while count
// and unused ops go straight to the result. One item at a time: the next beat
// is taken in the cycle after the result is loaded into the output register.
// Reset (synchronous, i_rst_n low) empties the table, zeroes the port counter
// and both registers; table RAM is not cleared.
module component_registration_table
    import crt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // op[2:0], component[10:3], instance[18:11], node[26:19],
    // subsystem[34:27], entry_address[66:35], entry_port[82:67],
    // handle[98:83], slot[106:99], zero fill[111:107]
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // Result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status[1:0], result_index[9:2], out_component[17:10], out_instance[25:18],
    // out_node[33:26], out_subsystem[41:34], out_address[73:42],
    // out_port[89:74], out_handle[105:90], entry_count[112:106], zero fill[119:113]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    // Index width for the table RAM, count width able to hold CAPACITY itself.
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_host_address;
    logic [15:0] r_first_port;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_address <= '0;
            r_first_port   <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HOST_ADDRESS) begin
                r_host_address <= pwdata;
            end else begin
                r_first_port <= pwdata[15:0];
            end
        end
    end

    // Byte offset bits paddr[1:0] are ignored; each register takes one word.
    always_comb begin
        case (paddr[2])
            REG_HOST_ADDRESS: prdata = r_host_address;
            REG_FIRST_PORT:   prdata = {16'd0, r_first_port};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic [2:0]  in_op;
    logic [31:0] in_key;
    logic [31:0] in_address;
    logic [15:0] in_port;
    logic [15:0] in_handle;
    logic [7:0]  in_slot;
    logic        s_acc;

    assign in_op      = i_s_tdata[2:0];
    assign in_key     = {i_s_tdata[10:3], i_s_tdata[18:11], i_s_tdata[26:19],
                         i_s_tdata[34:27]};
    assign in_address = i_s_tdata[66:35];
    assign in_port    = i_s_tdata[82:67];
    assign in_handle  = i_s_tdata[98:83];
    assign in_slot    = i_s_tdata[106:99];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_used, n_used;
    logic [15:0]         r_port_off, n_port_off;
    logic [CW-1:0]       r_idx, n_idx;      // next entry to read
    logic [IW-1:0]       r_pidx, n_pidx;    // entry whose read data is due
    logic                r_pend, n_pend;    // a read was issued last cycle
    logic                r_out_vld, n_out_vld;
    logic [M_DATA_W-1:0] r_out, n_out;
    t_result             r_res, n_res;
    logic [2:0]          r_op, n_op;
    logic [31:0]         r_key, n_key;
    logic [31:0]         r_address, n_address;
    logic [15:0]         r_port, n_port;
    logic [15:0]         r_handle, n_handle;

    // Table RAM
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;

    crt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // The shared compare unit: one stored entry against the request per cycle.
    logic op_is_key;
    logic op_is_add;
    logic cmp_hit;
    logic scan_more;

    assign op_is_key = (r_op == OP_FIND_KEY) || (r_op == OP_ADD_KEY);
    assign op_is_add = (r_op == OP_ADD_KEY) || (r_op == OP_ADD_HANDLE);
    assign cmp_hit   = r_pend && (op_is_key
                       ? ({ram_rdata.component, ram_rdata.inst, ram_rdata.node,
                           ram_rdata.subsystem} == r_key)
                       : (ram_rdata.handle == r_handle));
    assign scan_more = (r_idx < r_used);

    // The new entry for an append, with host address and port allocation.
    t_entry new_entry;

    always_comb begin
        new_entry.component   = r_key[31:24];
        new_entry.inst        = r_key[23:16];
        new_entry.node        = r_key[15:8];
        new_entry.subsystem   = r_key[7:0];
        new_entry.address     = (r_address == 32'd0) ? r_host_address : r_address;
        new_entry.port        = (r_port == 16'd0) ? (r_first_port + r_port_off) : r_port;
        new_entry.handle      = r_handle;
    end

    assign ram_waddr = r_used[IW-1:0];
    assign ram_wdata = new_entry;

    always_comb begin
        t_result miss_res;

        miss_res        = '0;
        miss_res.status = ST_MISS;

        n_state    = r_state;
        n_used     = r_used;
        n_port_off = r_port_off;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pend     = r_pend;
        n_out      = r_out;
        n_res      = r_res;
        n_op       = r_op;
        n_key      = r_key;
        n_address  = r_address;
        n_port     = r_port;
        n_handle   = r_handle;
        ram_we     = 1'b0;
        ram_raddr  = r_idx[IW-1:0];

        // Drop the output beat once it has been taken.
        n_out_vld  = r_out_vld & ~i_m_tready;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op      = in_op;
                    n_key     = in_key;
                    n_address = in_address;
                    n_port    = in_port;
                    n_handle  = in_handle;
                    case (in_op)
                        OP_FIND_KEY, OP_FIND_HANDLE, OP_ADD_KEY, OP_ADD_HANDLE: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SEARCH;
                        end
                        OP_READ_INDEX: begin
                            if (9'(in_slot) < 9'(r_used)) begin
                                ram_raddr = in_slot[IW-1:0];
                                n_pidx    = in_slot[IW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_res   = miss_res;
                                n_state = S_DONE;
                            end
                        end
                        OP_COUNT: begin
                            n_res = '0;
                            if (r_used != '0) begin
                                n_res.status = ST_OK;
                                n_res.index  = 8'(9'(r_used) - 9'd1);
                            end else begin
                                n_res.status = ST_MISS;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_res   = miss_res;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (cmp_hit) begin
                    // First match wins: report it and stop the scan.
                    n_res.status = op_is_add ? ST_PRESENT : ST_OK;
                    n_res.index  = 8'(r_pidx);
                    n_res.entry  = ram_rdata;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                end else if (scan_more) begin
                    // Issue the next read; its data is compared next cycle.
                    n_pidx = r_idx[IW-1:0];
                    n_pend = 1'b1;
                    n_idx  = CW'(r_idx + 1'b1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    if (!op_is_add) begin
                        n_res = miss_res;
                    end else if (r_used == CW'(CAPACITY)) begin
                        n_res        = '0;
                        n_res.status = ST_FULL;
                    end else begin
                        // Append at the end of the table.
                        ram_we       = 1'b1;
                        n_used       = CW'(r_used + 1'b1);
                        n_res.status = ST_OK;
                        n_res.index  = 8'(r_used);
                        n_res.entry  = new_entry;
                        if (r_port == 16'd0) begin
                            n_port_off = r_port_off + 16'd1;
                        end
                    end
                end
            end

            S_READ: begin
                n_res.status = ST_OK;
                n_res.index  = 8'(r_pidx);
                n_res.entry  = ram_rdata;
                n_state      = S_DONE;
            end

            S_DONE: begin
                // Load the output register as soon as it is free.
                if (!r_out_vld || i_m_tready) begin
                    n_out     = {7'd0, 7'(r_used),
                                 r_res.entry.handle, r_res.entry.port,
                                 r_res.entry.address, r_res.entry.subsystem,
                                 r_res.entry.node, r_res.entry.inst,
                                 r_res.entry.component, r_res.index, r_res.status};
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_port_off <= '0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_port_off <= n_port_off;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_out     <= n_out;
        r_res     <= n_res;
        r_op      <= n_op;
        r_key     <= n_key;
        r_address <= n_address;
        r_port    <= n_port;
        r_handle  <= n_handle;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("request accepted while an item is still in work");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_used < CW'(CAPACITY)))
        else $error("append into a full table");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_used == CW'($past(r_used) + 1'b1)))
        else $error("append did not advance the entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == ST_FULL) |-> (r_used == CW'(CAPACITY)))
        else $error("table full reported below capacity");

endmodule
